### hdl/bmalloc_pkg.sv
package bmalloc_pkg;

    // Map geometry; the block count is a multiple of the word width
    localparam int NumBlocks = 1024;
    localparam int WordBits  = 32;
    localparam int Words     = NumBlocks / WordBits;
    localparam int IdxW      = 10;
    localparam int BitW      = $clog2(WordBits);
    localparam int WordW     = $clog2(Words);

    // Command codes
    localparam logic CmdAlloc = 1'b0;
    localparam logic CmdFree  = 1'b1;

    typedef logic [IdxW-1:0]     t_idx;
    typedef logic [WordBits-1:0] t_word;
    typedef logic [WordW-1:0]    t_waddr;
    typedef logic [BitW-1:0]     t_bit;

    // Write port of the map memory
    typedef struct packed {
        logic   en;
        t_waddr addr;
        t_word  data;
    } t_wr;

    // Result handed from the controller to the output register
    typedef struct packed {
        t_idx block_index;
        logic success;
    } t_res;

endpackage

### hdl/bitmap_first_free_block_allocator.sv
// Bitmap first-fit block allocator.
// Input channel: i_in_valid / o_in_stall with i_command (0 allocate, 1 free)
// and i_free_index. Output channel: o_out_valid / i_out_stall with
// o_block_index and o_success, one result per input transaction, in order.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into first_data_block
// (lowest index allocation may return); write only while the block is idle.
// The used map lives in a 32-word by 32-bit memory with a registered read.
// Allocate reads one word per cycle starting at the word that holds
// first_data_block and scans up to the last word; a free takes one
// read-modify-write. The next transaction is accepted only after the
// result of the current one has moved to the output register.
// The result goes to an output register, so a new transaction is accepted
// while a stalled result waits; a second result is held in the controller
// until the output register frees, and input stall stays high meanwhile.
// Reset clears the per-word valid bits at once, so the whole map reads as
// free immediately after reset, and first_data_block returns to 1.
module bitmap_first_free_block_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [9:0]               i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_command,
    input  logic [9:0]               i_free_index,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [9:0]               o_block_index,
    output logic                     o_success
);

    bmalloc_pkg::t_idx    r_first_data_block;
    logic                 r_out_valid;
    bmalloc_pkg::t_res    r_out;

    logic                 res_valid;
    logic                 res_take;
    bmalloc_pkg::t_res    res;
    bmalloc_pkg::t_wr     wr;
    bmalloc_pkg::t_waddr  rd_addr;
    bmalloc_pkg::t_word   rd_data;

    // Hold the start register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_data_block <= bmalloc_pkg::IdxW'(1);
        end else if (i_cfg_wr_en) begin
            r_first_data_block <= i_cfg_wr_data;
        end
    end

    bmalloc_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_free_index       (i_free_index),
        .i_first_data_block (r_first_data_block),
        .o_res_valid        (res_valid),
        .o_res              (res),
        .i_res_take         (res_take),
        .o_wr               (wr),
        .o_rd_addr          (rd_addr),
        .i_rd_data          (rd_data)
    );

    bmalloc_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_block_index = r_out.block_index;
    assign o_success     = r_out.success;

endmodule

### hdl/bmalloc_ram.sv
module bmalloc_ram (
    input  logic                 i_clk,
    input  bmalloc_pkg::t_wr     i_wr,
    input  bmalloc_pkg::t_waddr  i_rd_addr,
    output bmalloc_pkg::t_word   o_rd_data
);

    bmalloc_pkg::t_word r_mem [bmalloc_pkg::Words];
    bmalloc_pkg::t_word r_rd_data;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/bmalloc_ctrl.sv
module bmalloc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  bmalloc_pkg::t_idx    i_free_index,
    input  bmalloc_pkg::t_idx    i_first_data_block,
    output logic                 o_res_valid,
    output bmalloc_pkg::t_res    o_res,
    input  logic                 i_res_take,
    output bmalloc_pkg::t_wr     o_wr,
    output bmalloc_pkg::t_waddr  o_rd_addr,
    input  bmalloc_pkg::t_word   i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_OUT
    } t_state;

    t_state                r_state;
    logic                  r_word_vld [bmalloc_pkg::Words];
    logic                  r_rd_vld;
    bmalloc_pkg::t_waddr   r_chk_w;
    bmalloc_pkg::t_bit     r_bit;
    bmalloc_pkg::t_word    r_mask;
    bmalloc_pkg::t_res     r_res;

    logic                  in_acc;
    logic                  hit;
    logic                  last_word;
    logic                  free_oor;
    logic                  alloc_oor;
    bmalloc_pkg::t_bit     pos;
    bmalloc_pkg::t_word    word_data;
    bmalloc_pkg::t_word    eff;
    bmalloc_pkg::t_waddr   free_w;
    bmalloc_pkg::t_waddr   start_w;
    bmalloc_pkg::t_wr      wr;

    // Decode the incoming transaction
    always_comb begin
        in_acc    = (r_state == S_IDLE) && i_in_valid;
        free_w    = bmalloc_pkg::WordW'(i_free_index >> bmalloc_pkg::BitW);
        start_w   = bmalloc_pkg::WordW'(i_first_data_block >> bmalloc_pkg::BitW);
        free_oor  = 32'(i_free_index) >= bmalloc_pkg::NumBlocks;
        alloc_oor = 32'(i_first_data_block) >= bmalloc_pkg::NumBlocks;
    end

    // Read address: first word on accept, next word while scanning
    always_comb begin
        if (r_state == S_IDLE) begin
            o_rd_addr = (i_command == bmalloc_pkg::CmdFree) ? free_w : start_w;
        end else begin
            o_rd_addr = r_chk_w + bmalloc_pkg::WordW'(1);
        end
    end

    // Find the lowest free bit of the word under test
    always_comb begin
        word_data = r_rd_vld ? i_rd_data : '0;
        eff       = word_data | r_mask;
        hit       = 1'b0;
        pos       = '0;
        for (int i = bmalloc_pkg::WordBits - 1; i >= 0; i--) begin
            if (!eff[i]) begin
                hit = 1'b1;
                pos = bmalloc_pkg::BitW'(i);
            end
        end
        last_word = r_chk_w == bmalloc_pkg::WordW'(bmalloc_pkg::Words - 1);
    end

    // Write back: set the found bit, or clear the freed bit
    always_comb begin
        wr.addr = r_chk_w;
        if (r_state == S_FREE) begin
            wr.en   = 1'b1;
            wr.data = word_data & ~(bmalloc_pkg::t_word'(1) << r_bit);
        end else begin
            wr.en   = (r_state == S_SCAN) && hit;
            wr.data = word_data | (bmalloc_pkg::t_word'(1) << pos);
        end
    end

    assign o_wr        = wr;
    assign o_in_stall  = r_state != S_IDLE;
    assign o_res_valid = r_state == S_OUT;
    assign o_res       = r_res;

    // Sequencer, word valid bits and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            for (int i = 0; i < bmalloc_pkg::Words; i++) begin
                r_word_vld[i] <= 1'b0;
            end
        end else begin
            r_rd_vld <= r_word_vld[o_rd_addr];
            if (wr.en) begin
                r_word_vld[wr.addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_command == bmalloc_pkg::CmdFree) begin
                            r_chk_w <= free_w;
                            r_bit   <= bmalloc_pkg::BitW'(i_free_index);
                            if (free_oor) begin
                                r_res   <= '{block_index: '0, success: 1'b0};
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_FREE;
                            end
                        end else begin
                            r_chk_w <= start_w;
                            r_mask  <= (bmalloc_pkg::t_word'(1)
                                        << bmalloc_pkg::BitW'(i_first_data_block))
                                       - bmalloc_pkg::t_word'(1);
                            if (alloc_oor) begin
                                r_res   <= '{block_index: '0, success: 1'b0};
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_mask <= '0;
                    if (hit) begin
                        r_res   <= '{block_index: bmalloc_pkg::IdxW'({r_chk_w, pos}),
                                     success: 1'b1};
                        r_state <= S_OUT;
                    end else if (last_word) begin
                        r_res   <= '{block_index: '0, success: 1'b0};
                        r_state <= S_OUT;
                    end else begin
                        r_chk_w <= r_chk_w + bmalloc_pkg::WordW'(1);
                    end
                end
                S_FREE: begin
                    r_res   <= '{block_index: '0, success: 1'b1};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Map writes only happen while finishing an allocate or a free
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_state == S_SCAN || r_state == S_FREE))
        else $error("map write outside scan or free");

    // A failed command reports index zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.success) |-> (o_res.block_index == '0))
        else $error("failure with nonzero index");

    // An accepted transaction leaves idle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("controller stayed idle after accept");

    // A held result stays stable until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_take) |=> (o_res_valid && $stable(o_res)))
        else $error("result changed before it was taken");
`endif

endmodule
